/* design/sv39pt_pkg.sv */
package sv39pt_pkg;

  // Table store geometry
  localparam int TABLE_PAGES       = 64;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int PAGE_W            = $clog2(TABLE_PAGES);
  localparam int FREE_W            = $clog2(TABLE_PAGES + 1);
  localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
  localparam int ADDR_W            = PAGE_W + IDX_W;
  localparam int STORE_DEPTH       = TABLE_PAGES * ENTRIES_PER_TABLE;

  // Entry and field widths
  localparam int ENTRY_W = 64;
  localparam int FLAG_W  = 10;
  localparam int VPN_W   = 27;
  localparam int PPN_W   = 44;
  localparam int CNT_W   = 17;
  localparam int PERM_W  = 10;
  localparam int STAT_W  = 2;

  // Stream word layout
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 8;

  // Config port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 64;

  typedef enum logic {
    OP_MAP   = 1'b0,
    OP_PROBE = 1'b1
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_OUTSIDE = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_ZERO,
    ST_IDLE,
    ST_RD2,
    ST_CK2,
    ST_RD1,
    ST_CK1,
    ST_RD0,
    ST_CK0,
    ST_LEAF,
    ST_RESP
  } state_e;

endpackage

/* design/sv39_page_table_map_and_probe.sv */
// Probe: the accepted word is walked from the root table down, at most to the leaf table,
// a read and a check per level, and the result word is loaded into the output register.
// Map: per page two table reads, two checks and one leaf write, and each new table page is
// first cleared one entry per cycle on the store port. One item at a time; a finished result
// waits in the output register while the next word is taken. Reset is asynchronous, active
// low; after reset the root page is cleared, no input word accepted meanwhile.
module sv39_page_table_map_and_probe (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [26:0] virt_page, [70:27] phys_page, [87:71] page_count, [97:88] permission
  input  logic [sv39pt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [0] operation
  input  logic                                 s_axis_tuser,
  // result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [0] is_mapped, [2:1] status
  output logic [sv39pt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // config port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [sv39pt_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [sv39pt_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [sv39pt_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                 pready
);

  localparam int PW = sv39pt_pkg::PAGE_W;
  localparam int IW = sv39pt_pkg::IDX_W;

  sv39pt_pkg::state_e              state_q, state_d, ret_q;
  logic [sv39pt_pkg::PPN_W-1:0]    pool_base_q;
  logic [sv39pt_pkg::FREE_W-1:0]   next_free_q;
  logic [PW-1:0]                   zpage_q;
  logic [IW-1:0]                   clr_cnt_q;
  logic [PW-1:0]                   pg_q;
  sv39pt_pkg::op_e                 op_q;
  logic [sv39pt_pkg::VPN_W-1:0]    vpn_q;
  logic [sv39pt_pkg::PPN_W-1:0]    ppn_q;
  logic [sv39pt_pkg::CNT_W-1:0]    cnt_q;
  logic [sv39pt_pkg::PERM_W-1:0]   perm_q;
  logic                            res_mapped_q;
  sv39pt_pkg::status_e             res_status_q;
  logic                            out_valid_q;
  logic                            out_mapped_q;
  sv39pt_pkg::status_e             out_status_q;

  logic                            ram_we, ram_re;
  logic [sv39pt_pkg::ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [sv39pt_pkg::ENTRY_W-1:0]  ram_wdata, ram_rdata;

  logic                            in_acc, out_load, cfg_wr;
  logic                            ent_valid, ptr_in, full, take_page;
  logic [sv39pt_pkg::PPN_W-1:0]    ptr_off, new_ptr;
  logic [PW-1:0]                   np;
  logic [IW-1:0]                   idx2, idx1, idx0;

  sv39pt_ram #(
    .WIDTH(sv39pt_pkg::ENTRY_W),
    .DEPTH(sv39pt_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Config register
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & ~paddr[3];
  assign prdata = paddr[3] ? '0
                : {{(sv39pt_pkg::CFG_DATA_W - sv39pt_pkg::PPN_W){1'b0}}, pool_base_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= '0;
    end else if (cfg_wr) begin
      pool_base_q <= pwdata[sv39pt_pkg::PPN_W-1:0];
    end
  end

  // Walk indices per level
  assign idx2 = vpn_q[2*IW +: IW];
  assign idx1 = vpn_q[IW +: IW];
  assign idx0 = vpn_q[0 +: IW];

  // Entry decode: pointer to store page, range check against the pool
  assign ent_valid = ram_rdata[0];
  assign ptr_off   = ram_rdata[sv39pt_pkg::FLAG_W +: sv39pt_pkg::PPN_W] - pool_base_q;
  assign ptr_in    = ptr_off < sv39pt_pkg::PPN_W'(sv39pt_pkg::TABLE_PAGES);
  assign full      = next_free_q == sv39pt_pkg::FREE_W'(sv39pt_pkg::TABLE_PAGES);
  assign np        = next_free_q[PW-1:0];
  assign new_ptr   = sv39pt_pkg::PPN_W'(np) + pool_base_q;
  assign take_page = (state_q == sv39pt_pkg::ST_CK2 || state_q == sv39pt_pkg::ST_CK1)
                   && !ent_valid && op_q == sv39pt_pkg::OP_MAP && !full;

  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign out_load = (state_q == sv39pt_pkg::ST_RESP) & (~out_valid_q | m_axis_tready);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sv39pt_pkg::ST_ZERO: begin
        if (clr_cnt_q == '1) state_d = ret_q;
      end
      sv39pt_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (sv39pt_pkg::op_e'(s_axis_tuser) == sv39pt_pkg::OP_MAP
              && s_axis_tdata[71 +: sv39pt_pkg::CNT_W] == '0) begin
            state_d = sv39pt_pkg::ST_RESP;
          end else begin
            state_d = sv39pt_pkg::ST_RD2;
          end
        end
      end
      sv39pt_pkg::ST_RD2: state_d = sv39pt_pkg::ST_CK2;
      sv39pt_pkg::ST_CK2: begin
        priority if (ent_valid) begin
          state_d = ptr_in ? sv39pt_pkg::ST_RD1 : sv39pt_pkg::ST_RESP;
        end else if (op_q == sv39pt_pkg::OP_PROBE || full) begin
          state_d = sv39pt_pkg::ST_RESP;
        end else begin
          state_d = sv39pt_pkg::ST_ZERO;
        end
      end
      sv39pt_pkg::ST_RD1: state_d = sv39pt_pkg::ST_CK1;
      sv39pt_pkg::ST_CK1: begin
        priority if (ent_valid) begin
          if (!ptr_in) state_d = sv39pt_pkg::ST_RESP;
          else if (op_q == sv39pt_pkg::OP_PROBE) state_d = sv39pt_pkg::ST_RD0;
          else state_d = sv39pt_pkg::ST_LEAF;
        end else if (op_q == sv39pt_pkg::OP_PROBE || full) begin
          state_d = sv39pt_pkg::ST_RESP;
        end else begin
          state_d = sv39pt_pkg::ST_ZERO;
        end
      end
      sv39pt_pkg::ST_RD0: state_d = sv39pt_pkg::ST_CK0;
      sv39pt_pkg::ST_CK0: state_d = sv39pt_pkg::ST_RESP;
      sv39pt_pkg::ST_LEAF: begin
        state_d = (cnt_q == sv39pt_pkg::CNT_W'(1)) ? sv39pt_pkg::ST_RESP
                                                   : sv39pt_pkg::ST_RD2;
      end
      sv39pt_pkg::ST_RESP: begin
        if (out_load) state_d = sv39pt_pkg::ST_IDLE;
      end
      default: state_d = sv39pt_pkg::ST_IDLE;
    endcase
  end

  // Store port and handshake outputs
  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = '0;
    ram_raddr     = '0;
    ram_wdata     = '0;
    unique case (state_q)
      sv39pt_pkg::ST_ZERO: begin
        ram_we    = 1'b1;
        ram_waddr = {zpage_q, clr_cnt_q};
      end
      sv39pt_pkg::ST_IDLE: s_axis_tready = 1'b1;
      sv39pt_pkg::ST_RD2: begin
        ram_re    = 1'b1;
        ram_raddr = {PW'(0), idx2};
      end
      sv39pt_pkg::ST_RD1: begin
        ram_re    = 1'b1;
        ram_raddr = {pg_q, idx1};
      end
      sv39pt_pkg::ST_RD0: begin
        ram_re    = 1'b1;
        ram_raddr = {pg_q, idx0};
      end
      sv39pt_pkg::ST_CK2, sv39pt_pkg::ST_CK1: begin
        // new pointer entry into the slot just read
        ram_we    = take_page;
        ram_waddr = (state_q == sv39pt_pkg::ST_CK2) ? {PW'(0), idx2} : {pg_q, idx1};
        ram_wdata = {{(sv39pt_pkg::ENTRY_W - sv39pt_pkg::FLAG_W - sv39pt_pkg::PPN_W){1'b0}},
                     new_ptr, {(sv39pt_pkg::FLAG_W - 1){1'b0}}, 1'b1};
      end
      sv39pt_pkg::ST_LEAF: begin
        ram_we    = 1'b1;
        ram_waddr = {pg_q, idx0};
        ram_wdata = {{(sv39pt_pkg::ENTRY_W - sv39pt_pkg::FLAG_W - sv39pt_pkg::PPN_W){1'b0}},
                     ppn_q, perm_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= sv39pt_pkg::ST_ZERO;
    else         state_q <= state_d;
  end

  // Control registers: free pointer, clear sweep, run count, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_free_q <= sv39pt_pkg::FREE_W'(1);
      zpage_q     <= '0;
      clr_cnt_q   <= '0;
      ret_q       <= sv39pt_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == sv39pt_pkg::ST_ZERO) clr_cnt_q <= clr_cnt_q + IW'(1);
      if (take_page) begin
        next_free_q <= next_free_q + sv39pt_pkg::FREE_W'(1);
        zpage_q     <= np;
        clr_cnt_q   <= '0;
        ret_q       <= (state_q == sv39pt_pkg::ST_CK2) ? sv39pt_pkg::ST_RD1
                                                       : sv39pt_pkg::ST_LEAF;
      end
      if (in_acc) cnt_q <= s_axis_tdata[71 +: sv39pt_pkg::CNT_W];
      else if (state_q == sv39pt_pkg::ST_LEAF) cnt_q <= cnt_q - sv39pt_pkg::CNT_W'(1);
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // Walk payload and result
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q         <= sv39pt_pkg::op_e'(s_axis_tuser);
      vpn_q        <= s_axis_tdata[0 +: sv39pt_pkg::VPN_W];
      ppn_q        <= s_axis_tdata[27 +: sv39pt_pkg::PPN_W];
      perm_q       <= s_axis_tdata[88 +: sv39pt_pkg::PERM_W];
      res_mapped_q <= 1'b0;
      res_status_q <= sv39pt_pkg::STAT_OK;
    end
    if (state_q == sv39pt_pkg::ST_CK2 || state_q == sv39pt_pkg::ST_CK1) begin
      if (ent_valid) begin
        if (ptr_in) pg_q <= ptr_off[PW-1:0];
        else        res_status_q <= sv39pt_pkg::STAT_OUTSIDE;
      end else if (op_q == sv39pt_pkg::OP_MAP) begin
        if (full) res_status_q <= sv39pt_pkg::STAT_FULL;
        else      pg_q <= np;
      end
    end
    if (state_q == sv39pt_pkg::ST_CK0) res_mapped_q <= ent_valid;
    if (state_q == sv39pt_pkg::ST_LEAF) begin
      vpn_q <= vpn_q + sv39pt_pkg::VPN_W'(1);
      ppn_q <= ppn_q + sv39pt_pkg::PPN_W'(1);
    end
    if (out_load) begin
      out_mapped_q <= res_mapped_q;
      out_status_q <= res_status_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(sv39pt_pkg::OUT_DATA_W - 1 - sv39pt_pkg::STAT_W){1'b0}},
                          out_status_q, out_mapped_q};

`ifndef SYNTH
  // free pointer never runs past the pool
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_free_q <= sv39pt_pkg::FREE_W'(sv39pt_pkg::TABLE_PAGES))
    else $error("free table pointer beyond pool");

  // store is never read and written in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ram_we && ram_re))
    else $error("store read and write overlap");

  // the free pointer advances by one on every page take
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_page |=> next_free_q == $past(next_free_q) + sv39pt_pkg::FREE_W'(1))
    else $error("free pointer not advanced on page take");
`endif

endmodule

/* design/sv39pt_ram.sv */
module sv39pt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
